### hw/rtl/first_fit_unit_allocator_top_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_UNIT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define FFA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Consequence must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### hw/rtl/ffa_pkg.sv
// Shared types, widths and codes of the first-fit unit allocator.
package ffa_pkg;

  localparam int REQ_TYPE_W   = 2;
  localparam int OFFSET_W     = 10;
  localparam int SIZE_W       = 11;
  localparam int STATUS_W     = 2;
  localparam int POOL_UNITS_W = 11;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam int POOL_DEPTH_DEF = 1024;
  localparam int MAX_BLOCKS_DEF = 64;

  localparam logic [POOL_UNITS_W-1:0] POOL_UNITS_RST = 11'd1024;
  localparam logic [PADDR_W-1:0]      REG_POOL_ADDR  = 3'd0;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_RESIZE = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MK_ALL,
    MK_RUN,
    MK_OLD,
    MK_TAIL
  } mark_sel_e;

  typedef enum logic [2:0] {
    FR_NONE,
    FR_SUB_SIZE,
    FR_ADD_LEN,
    FR_ADD_TAIL,
    FR_SUB_GROW
  } free_op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RUN,
    RES_ENTRY
  } res_sel_e;

  typedef enum logic [3:0] {
    S_CLR0,
    S_CLRW,
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_MARK,
    S_MARKO,
    S_SRCH,
    S_ENT,
    S_FREEM,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic      req_load;
    logic      clr_state;
    logic      mk_load;
    mark_sel_e mk_sel;
    logic      sc_start;
    logic      es_start;
    logic      sh_start;
    logic      alloc_wr;
    logic      upd_wr;
    logic      upd_new;
    logic      cnt_dec;
    free_op_e  fr_op;
    logic      res_load;
    status_e   res_st;
    res_sel_e  res_sel;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic mk_done;
    logic sc_hit;
    logic sc_fail;
    logic es_hit;
    logic es_fail;
    logic sh_done;
    logic size_zero;
    logic size_gt_free;
    logic tbl_full;
    logic size_eq_len;
    logic size_lt_len;
    logic grow_gt_free;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/ffa_dp.sv
// Datapath: unit bitmap, block table, scan/search/shift/mark engines, counters.
module ffa_dp #(
  parameter int POOL_DEPTH = ffa_pkg::POOL_DEPTH_DEF,
  parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffa_pkg::cmd_t                   cmd_i,
  output ffa_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [ffa_pkg::POOL_UNITS_W-1:0] cfg_data_i,
  output logic [ffa_pkg::POOL_UNITS_W-1:0] pool_units_o,
  input  logic [ffa_pkg::REQ_TYPE_W-1:0]  req_type_i,
  input  logic [ffa_pkg::OFFSET_W-1:0]    block_offset_i,
  input  logic [ffa_pkg::SIZE_W-1:0]      req_size_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [ffa_pkg::STATUS_W-1:0]    status_o,
  output logic [ffa_pkg::OFFSET_W-1:0]    result_offset_o
);

  localparam int PW  = $clog2(POOL_DEPTH);
  localparam int LW  = $clog2(POOL_DEPTH + 1);
  localparam int EW  = $clog2(MAX_BLOCKS);
  localparam int CNW = $clog2(MAX_BLOCKS + 1);
  localparam int CW  = (LW > ffa_pkg::SIZE_W) ? LW : ffa_pkg::SIZE_W;
  localparam int AW  = (PW > ffa_pkg::OFFSET_W) ? PW : ffa_pkg::OFFSET_W;
  localparam int EDW = PW + LW;

  // storage
  logic           unit_mem [POOL_DEPTH];
  logic [EDW-1:0] ent_mem  [MAX_BLOCKS];
  logic           unit_rd_q;
  logic [EDW-1:0] ent_rd_q;

  // configuration and counters
  logic [ffa_pkg::POOL_UNITS_W-1:0] pool_q;
  logic [LW-1:0]  eff_pool;
  logic [CNW-1:0] count_q;
  logic [LW-1:0]  free_q;

  // captured request
  ffa_pkg::req_e                req_type_q;
  logic [ffa_pkg::OFFSET_W-1:0] off_q;
  logic [CW-1:0]                size_q;

  // mark engine
  logic [PW-1:0] mk_addr_q;
  logic [LW-1:0] mk_cnt_q;
  logic          mk_val_q;

  // scan engine
  logic          sc_busy_q, sc_vld_q;
  logic [PW:0]   sc_addr_q;
  logic [PW-1:0] sc_daddr_q, sc_begin_q, sc_begin_w;
  logic [LW-1:0] sc_run_q, sc_run_inc;
  logic          sc_issue, sc_hit, sc_fail;

  // entry search engine
  logic           es_busy_q, es_vld_q;
  logic [CNW-1:0] es_addr_q;
  logic [EW-1:0]  es_didx_q;
  logic           es_issue, es_match, es_hit, es_fail;

  // shift engine
  logic           sh_busy_q, sh_vld_q;
  logic [CNW-1:0] sh_addr_q;
  logic [EW-1:0]  sh_wa_q;
  logic           sh_issue, sh_done;

  // found entry
  logic [EW-1:0] idx_q;
  logic [PW-1:0] ent_start_q;
  logic [LW-1:0] ent_len_q;

  // entry memory port
  logic           ent_we;
  logic [EW-1:0]  ent_wa, ent_ra;
  logic [EDW-1:0] ent_wd;

  // output register
  logic                         out_vld_q;
  ffa_pkg::status_e             out_st_q;
  logic [ffa_pkg::OFFSET_W-1:0] out_off_q;

  logic [CW-1:0] free_w, len_w;
  logic [PW-1:0] upd_start;

  always_comb begin
    logic [CW-1:0] pu_w;
    pu_w = CW'(pool_q);
    if (pu_w == '0) begin
      eff_pool = LW'(1);
    end else if (pu_w > CW'(POOL_DEPTH)) begin
      eff_pool = LW'(POOL_DEPTH);
    end else begin
      eff_pool = LW'(pu_w);
    end
  end

  assign free_w = CW'(free_q);
  assign len_w  = CW'(ent_len_q);

  // scan control
  assign sc_run_inc = sc_run_q + LW'(1);
  assign sc_issue   = sc_busy_q && (sc_addr_q < (PW+1)'(eff_pool));
  assign sc_hit     = sc_busy_q && sc_vld_q && !unit_rd_q && (CW'(sc_run_inc) == size_q);
  assign sc_fail    = sc_busy_q && !sc_vld_q && !sc_issue;
  // a one-unit run starts at the bit just processed
  assign sc_begin_w = (sc_run_q == '0) ? sc_daddr_q : sc_begin_q;

  // search control
  assign es_issue = es_busy_q && (es_addr_q < count_q);
  assign es_match = AW'(ent_rd_q[EDW-1:LW]) == AW'(off_q);
  assign es_hit   = es_busy_q && es_vld_q && es_match;
  assign es_fail  = es_busy_q && !es_vld_q && !es_issue;

  // shift control
  assign sh_issue = sh_busy_q && (sh_addr_q < count_q);
  assign sh_done  = sh_busy_q && !sh_vld_q && !sh_issue;

  assign ent_ra    = es_busy_q ? es_addr_q[EW-1:0] : sh_addr_q[EW-1:0];
  assign upd_start = cmd_i.upd_new ? sc_begin_q : ent_start_q;

  always_comb begin
    ent_we = 1'b0;
    ent_wa = sh_wa_q;
    ent_wd = ent_rd_q;
    if (cmd_i.alloc_wr) begin
      ent_we = 1'b1;
      ent_wa = count_q[EW-1:0];
      ent_wd = {sc_begin_w, LW'(size_q)};
    end else if (cmd_i.upd_wr) begin
      ent_we = 1'b1;
      ent_wa = idx_q;
      ent_wd = {upd_start, LW'(size_q)};
    end else if (sh_busy_q && sh_vld_q) begin
      ent_we = 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (mk_cnt_q != '0) begin
      unit_mem[mk_addr_q] <= mk_val_q;
    end
    if (sc_issue) begin
      unit_rd_q <= unit_mem[sc_addr_q[PW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (es_issue || sh_issue) begin
      ent_rd_q <= ent_mem[ent_ra];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_type_q <= ffa_pkg::req_e'(req_type_i);
      off_q      <= block_offset_i;
      size_q     <= CW'(req_size_i);
    end
    if (sc_busy_q && sc_vld_q && !unit_rd_q && (sc_run_q == '0)) begin
      sc_begin_q <= sc_daddr_q;
    end
    if (es_hit) begin
      idx_q       <= es_didx_q;
      ent_start_q <= ent_rd_q[EDW-1:LW];
      ent_len_q   <= ent_rd_q[LW-1:0];
    end
    sc_daddr_q <= sc_addr_q[PW-1:0];
    es_didx_q  <= es_addr_q[EW-1:0];
    sh_wa_q    <= EW'(sh_addr_q - CNW'(1));
    if (cmd_i.res_load) begin
      out_st_q <= cmd_i.res_st;
      case (cmd_i.res_sel)
        ffa_pkg::RES_RUN:   out_off_q <= ffa_pkg::OFFSET_W'(sc_begin_q);
        ffa_pkg::RES_ENTRY: out_off_q <= ffa_pkg::OFFSET_W'(ent_start_q);
        default:            out_off_q <= '0;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q    <= ffa_pkg::POOL_UNITS_RST;
      count_q   <= '0;
      free_q    <= '0;
      mk_addr_q <= '0;
      mk_cnt_q  <= '0;
      mk_val_q  <= 1'b0;
      sc_busy_q <= 1'b0;
      sc_vld_q  <= 1'b0;
      sc_addr_q <= '0;
      sc_run_q  <= '0;
      es_busy_q <= 1'b0;
      es_vld_q  <= 1'b0;
      es_addr_q <= '0;
      sh_busy_q <= 1'b0;
      sh_vld_q  <= 1'b0;
      sh_addr_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_q <= cfg_data_i;
      end

      if (cmd_i.clr_state) begin
        count_q <= '0;
      end else if (cmd_i.alloc_wr) begin
        count_q <= count_q + CNW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNW'(1);
      end

      if (cmd_i.clr_state) begin
        free_q <= eff_pool;
      end else begin
        case (cmd_i.fr_op)
          ffa_pkg::FR_SUB_SIZE: free_q <= LW'(free_w - size_q);
          ffa_pkg::FR_ADD_LEN:  free_q <= LW'(free_w + len_w);
          ffa_pkg::FR_ADD_TAIL: free_q <= LW'(free_w + (len_w - size_q));
          ffa_pkg::FR_SUB_GROW: free_q <= LW'(free_w - (size_q - len_w));
          default:              free_q <= free_q;
        endcase
      end

      // mark engine: one unit per cycle
      if (cmd_i.mk_load) begin
        case (cmd_i.mk_sel)
          ffa_pkg::MK_ALL: begin
            mk_addr_q <= '0;
            mk_cnt_q  <= LW'(POOL_DEPTH);
            mk_val_q  <= 1'b0;
          end
          ffa_pkg::MK_RUN: begin
            mk_addr_q <= sc_begin_w;
            mk_cnt_q  <= LW'(size_q);
            mk_val_q  <= 1'b1;
          end
          ffa_pkg::MK_TAIL: begin
            mk_addr_q <= ent_start_q + PW'(size_q);
            mk_cnt_q  <= ent_len_q - LW'(size_q);
            mk_val_q  <= 1'b0;
          end
          default: begin
            mk_addr_q <= ent_start_q;
            mk_cnt_q  <= ent_len_q;
            mk_val_q  <= 1'b0;
          end
        endcase
      end else if (mk_cnt_q != '0) begin
        mk_addr_q <= mk_addr_q + PW'(1);
        mk_cnt_q  <= mk_cnt_q - LW'(1);
      end

      // scan engine: read one bit per cycle, process it in the next cycle
      if (cmd_i.sc_start) begin
        sc_busy_q <= 1'b1;
        sc_vld_q  <= 1'b0;
        sc_addr_q <= '0;
        sc_run_q  <= '0;
      end else if (sc_busy_q) begin
        sc_vld_q <= sc_issue;
        if (sc_issue) begin
          sc_addr_q <= sc_addr_q + (PW+1)'(1);
        end
        if (sc_vld_q) begin
          sc_run_q <= unit_rd_q ? '0 : sc_run_inc;
        end
        if (sc_hit || sc_fail) begin
          sc_busy_q <= 1'b0;
        end
      end

      // entry search
      if (cmd_i.es_start) begin
        es_busy_q <= 1'b1;
        es_vld_q  <= 1'b0;
        es_addr_q <= '0;
      end else if (es_busy_q) begin
        es_vld_q <= es_issue;
        if (es_issue) begin
          es_addr_q <= es_addr_q + CNW'(1);
        end
        if (es_hit || es_fail) begin
          es_busy_q <= 1'b0;
        end
      end

      // shift later entries down one slot
      if (cmd_i.sh_start) begin
        sh_busy_q <= 1'b1;
        sh_vld_q  <= 1'b0;
        sh_addr_q <= CNW'(idx_q) + CNW'(1);
      end else if (sh_busy_q) begin
        sh_vld_q <= sh_issue;
        if (sh_issue) begin
          sh_addr_q <= sh_addr_q + CNW'(1);
        end
        if (sh_done) begin
          sh_busy_q <= 1'b0;
        end
      end

      if (cmd_i.res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.req_type     = req_type_q;
    sts_o.mk_done      = (mk_cnt_q == '0);
    sts_o.sc_hit       = sc_hit;
    sts_o.sc_fail      = sc_fail;
    sts_o.es_hit       = es_hit;
    sts_o.es_fail      = es_fail;
    sts_o.sh_done      = sh_done;
    sts_o.size_zero    = (size_q == '0);
    sts_o.size_gt_free = (size_q > free_w);
    sts_o.tbl_full     = (count_q >= CNW'(MAX_BLOCKS));
    sts_o.size_eq_len  = (size_q == len_w);
    sts_o.size_lt_len  = (size_q < len_w);
    sts_o.grow_gt_free = ((size_q - len_w) > free_w);
    sts_o.out_busy     = out_vld_q && !out_ready_i;
  end

  assign pool_units_o    = pool_q;
  assign out_valid_o     = out_vld_q;
  assign status_o        = out_st_q;
  assign result_offset_o = out_off_q;

endmodule

### hw/rtl/ffa_ctrl.sv
// Controller: sequences each request over the datapath engines.
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cfg_we_i,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);

  ffa_pkg::state_e   state_q, state_d;
  ffa_pkg::status_e  pend_st_q, pend_st_d;
  ffa_pkg::res_sel_e pend_sel_q, pend_sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ffa_pkg::S_CLR0;
      pend_st_q  <= ffa_pkg::ST_OK;
      pend_sel_q <= ffa_pkg::RES_ZERO;
    end else begin
      state_q    <= state_d;
      pend_st_q  <= pend_st_d;
      pend_sel_q <= pend_sel_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend_st_d  = pend_st_q;
    pend_sel_d = pend_sel_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ffa_pkg::S_CLR0: begin
        cmd_o.mk_load   = 1'b1;
        cmd_o.mk_sel    = ffa_pkg::MK_ALL;
        cmd_o.clr_state = 1'b1;
        state_d         = ffa_pkg::S_CLRW;
      end
      ffa_pkg::S_CLRW: begin
        if (sts_i.mk_done) begin
          state_d = ffa_pkg::S_IDLE;
        end
      end
      ffa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ffa_pkg::S_DEC;
        end
      end
      ffa_pkg::S_DEC: begin
        pend_sel_d = ffa_pkg::RES_ZERO;
        state_d    = ffa_pkg::S_RESP;
        case (sts_i.req_type)
          ffa_pkg::REQ_ALLOC: begin
            if (sts_i.size_zero) begin
              pend_st_d = ffa_pkg::ST_OK;
            end else if (sts_i.size_gt_free) begin
              pend_st_d = ffa_pkg::ST_NOSPACE;
            end else if (sts_i.tbl_full) begin
              pend_st_d = ffa_pkg::ST_FULL;
            end else begin
              cmd_o.sc_start = 1'b1;
              state_d        = ffa_pkg::S_SCAN;
            end
          end
          ffa_pkg::REQ_FREE, ffa_pkg::REQ_RESIZE: begin
            cmd_o.es_start = 1'b1;
            state_d        = ffa_pkg::S_SRCH;
          end
          default: begin
            pend_st_d = ffa_pkg::ST_UNKNOWN;
          end
        endcase
      end
      ffa_pkg::S_SCAN: begin
        if (sts_i.sc_hit) begin
          pend_st_d  = ffa_pkg::ST_OK;
          pend_sel_d = ffa_pkg::RES_RUN;
          cmd_o.mk_load = 1'b1;
          if (sts_i.req_type == ffa_pkg::REQ_ALLOC) begin
            cmd_o.mk_sel   = ffa_pkg::MK_RUN;
            cmd_o.alloc_wr = 1'b1;
            cmd_o.fr_op    = ffa_pkg::FR_SUB_SIZE;
            state_d        = ffa_pkg::S_MARK;
          end else begin
            // drop the old run first, then claim the new one
            cmd_o.mk_sel = ffa_pkg::MK_OLD;
            state_d      = ffa_pkg::S_MARKO;
          end
        end else if (sts_i.sc_fail) begin
          pend_st_d  = ffa_pkg::ST_NOSPACE;
          pend_sel_d = ffa_pkg::RES_ZERO;
          state_d    = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_MARKO: begin
        if (sts_i.mk_done) begin
          cmd_o.mk_load = 1'b1;
          cmd_o.mk_sel  = ffa_pkg::MK_RUN;
          cmd_o.upd_wr  = 1'b1;
          cmd_o.upd_new = 1'b1;
          cmd_o.fr_op   = ffa_pkg::FR_SUB_GROW;
          state_d       = ffa_pkg::S_MARK;
        end
      end
      ffa_pkg::S_MARK: begin
        if (sts_i.mk_done) begin
          state_d = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_SRCH: begin
        if (sts_i.es_hit) begin
          state_d = ffa_pkg::S_ENT;
        end else if (sts_i.es_fail) begin
          pend_st_d  = ffa_pkg::ST_UNKNOWN;
          pend_sel_d = ffa_pkg::RES_ZERO;
          state_d    = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_ENT: begin
        pend_st_d  = ffa_pkg::ST_OK;
        pend_sel_d = ffa_pkg::RES_ENTRY;
        if (sts_i.req_type == ffa_pkg::REQ_FREE || sts_i.size_zero) begin
          cmd_o.mk_load = 1'b1;
          cmd_o.mk_sel  = ffa_pkg::MK_OLD;
          cmd_o.fr_op   = ffa_pkg::FR_ADD_LEN;
          pend_sel_d    = ffa_pkg::RES_ZERO;
          state_d       = ffa_pkg::S_FREEM;
        end else if (sts_i.size_eq_len) begin
          state_d = ffa_pkg::S_RESP;
        end else if (sts_i.size_lt_len) begin
          cmd_o.mk_load = 1'b1;
          cmd_o.mk_sel  = ffa_pkg::MK_TAIL;
          cmd_o.fr_op   = ffa_pkg::FR_ADD_TAIL;
          cmd_o.upd_wr  = 1'b1;
          state_d       = ffa_pkg::S_MARK;
        end else if (sts_i.grow_gt_free) begin
          pend_st_d  = ffa_pkg::ST_NOSPACE;
          pend_sel_d = ffa_pkg::RES_ZERO;
          state_d    = ffa_pkg::S_RESP;
        end else begin
          cmd_o.sc_start = 1'b1;
          state_d        = ffa_pkg::S_SCAN;
        end
      end
      ffa_pkg::S_FREEM: begin
        if (sts_i.mk_done) begin
          cmd_o.sh_start = 1'b1;
          state_d        = ffa_pkg::S_SHIFT;
        end
      end
      ffa_pkg::S_SHIFT: begin
        if (sts_i.sh_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st   = pend_st_q;
          cmd_o.res_sel  = pend_sel_q;
          state_d        = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffa_pkg::S_CLR0;
      end
    endcase

    // a pool size write restarts the clearing pass from any state
    if (cfg_we_i) begin
      state_d = ffa_pkg::S_CLR0;
    end
  end

endmodule

### hw/rtl/first_fit_unit_allocator_top.sv
// First-fit unit allocator: one request word in, one result word out.
//
// The block keeps an occupancy bit per allocation unit in a one-bit-wide memory
// and a table of live blocks (start, length) in a second memory. Each request
// word is answered by exactly one result word, in order. Depending on its
// kind, a request passes through a decode step, a search of the block table
// (free and resize), a first-fit scan of the unit bits (allocate and growing
// resize), the marking or clearing of units, a shift of later table entries
// down after a free, and the result step. The unit bitmap has one read and
// one write port and is touched one bit per cycle. One request is in work at
// a time; a finished result waits in the output register and the next request
// word may be accepted meanwhile. After reset and after every write of
// pool_units the block clears the whole bitmap with in_ready_o low; the pool
// register sits at byte address 0 of the APB port and reads back the low 11
// bits of the written value.
module first_fit_unit_allocator_top #(
  parameter int POOL_DEPTH = ffa_pkg::POOL_DEPTH_DEF,
  parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0]    paddr,
  input  logic [ffa_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffa_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ffa_pkg::REQ_TYPE_W-1:0] req_type_i,
  input  logic [ffa_pkg::OFFSET_W-1:0]   block_offset_i,
  input  logic [ffa_pkg::SIZE_W-1:0]     req_size_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ffa_pkg::STATUS_W-1:0]   status_o,
  output logic [ffa_pkg::OFFSET_W-1:0]   result_offset_o
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;
  logic          cfg_we;
  logic [ffa_pkg::POOL_UNITS_W-1:0] pool_units;

  // register write completes on the access cycle; the port never stalls
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ffa_pkg::REG_POOL_ADDR);
  assign prdata = (paddr == ffa_pkg::REG_POOL_ADDR) ? ffa_pkg::PDATA_W'(pool_units) : '0;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cfg_we_i   (cfg_we),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffa_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (pwdata[ffa_pkg::POOL_UNITS_W-1:0]),
    .pool_units_o    (pool_units),
    .req_type_i      (req_type_i),
    .block_offset_i  (block_offset_i),
    .req_size_i      (req_size_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .result_offset_o (result_offset_o)
  );

endmodule

### hw/rtl/ffa_checker.sv
// Port-level checks of the allocator, bound to the top level.
`include "first_fit_unit_allocator_top_macros.svh"

module ffa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ffa_pkg::PADDR_W-1:0]    paddr,
  input logic                           pready,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ffa_pkg::STATUS_W-1:0]   status_o,
  input logic [ffa_pkg::OFFSET_W-1:0]   result_offset_o
);

  // a stalled result word holds
  `FFA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(result_offset_o))

  // any error reports offset zero
  `FFA_ASSERT_SAME(a_err_zero, out_valid_o && (status_o != ffa_pkg::ST_OK), result_offset_o == '0)

  // one request in work at a time
  `FFA_ASSERT_NEXT(a_one_req, in_valid_i && in_ready_o, !in_ready_o)

  // a pool size write starts the clearing pass
  `FFA_ASSERT_NEXT(a_cfg_clear, psel && penable && pwrite && pready && (paddr == ffa_pkg::REG_POOL_ADDR), !in_ready_o)

endmodule

bind first_fit_unit_allocator_top ffa_checker u_ffa_checker (.*);

### tb/sv/first_fit_unit_allocator_top_tb.sv
// Testbench for the first-fit unit allocator: request stimulus, predictor and result checks.
`timescale 1ns / 100ps

// Scoreboard: own copy of the pool, block table and counters.
// It predicts one result word per accepted request and checks result words in order.
class alloc_scoreboard;
  bit               unit_busy [ffa_pkg::POOL_DEPTH_DEF];
  int unsigned      blk_start [ffa_pkg::MAX_BLOCKS_DEF];
  int unsigned      blk_len   [ffa_pkg::MAX_BLOCKS_DEF];
  int unsigned      blk_cnt;
  int unsigned      free_units;
  int unsigned      pool_reg;
  ffa_pkg::status_e exp_status [$];
  logic [9:0]       exp_offset [$];
  int               errors;

  function new();
    errors   = 0;
    pool_reg = 1024;
    wipe();
  endfunction

  function int unsigned eff_pool();
    int unsigned p;
    p = pool_reg;
    if (p == 0) p = 1;
    if (p > ffa_pkg::POOL_DEPTH_DEF) p = ffa_pkg::POOL_DEPTH_DEF;
    return p;
  endfunction

  function void wipe();
    foreach (unit_busy[i]) unit_busy[i] = 1'b0;
    blk_cnt    = 0;
    free_units = eff_pool();
  endfunction

  function void set_pool(int unsigned v);
    pool_reg = v & 32'h7FF;
    wipe();
  endfunction

  // Lowest start of a free run of len units, -1 if none.
  function int first_fit(int unsigned len);
    int unsigned run, from;
    run  = 0;
    from = 0;
    for (int unsigned i = 0; i < eff_pool(); i++) begin
      if (!unit_busy[i]) begin
        if (run == 0) from = i;
        run++;
        if (run == len) return from;
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  function void paint(int unsigned from, int unsigned len, bit v);
    for (int unsigned i = 0; i < len; i++)
      if (from + i < ffa_pkg::POOL_DEPTH_DEF) unit_busy[from + i] = v;
  endfunction

  function int lookup(int unsigned off);
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (blk_start[i] == off) return i;
    return -1;
  endfunction

  function void drop_block(int unsigned idx);
    paint(blk_start[idx], blk_len[idx], 1'b0);
    free_units += blk_len[idx];
    for (int unsigned i = idx; i + 1 < blk_cnt; i++) begin
      blk_start[i] = blk_start[i + 1];
      blk_len[i]   = blk_len[i + 1];
    end
    blk_cnt--;
  endfunction

  // Predict the result of one accepted request word and queue it.
  function void note_request(logic [1:0] kind, int unsigned off, int unsigned size);
    ffa_pkg::status_e st;
    int unsigned      res, grow;
    int               idx, at;
    st  = ffa_pkg::ST_OK;
    res = 0;
    case (kind)
      ffa_pkg::REQ_ALLOC: begin
        if (size == 0) begin
          st = ffa_pkg::ST_OK;
        end else if (size > free_units) begin
          st = ffa_pkg::ST_NOSPACE;
        end else if (blk_cnt >= ffa_pkg::MAX_BLOCKS_DEF) begin
          st = ffa_pkg::ST_FULL;
        end else begin
          at = first_fit(size);
          if (at < 0) begin
            st = ffa_pkg::ST_NOSPACE;
          end else begin
            paint(at, size, 1'b1);
            blk_start[blk_cnt] = at;
            blk_len[blk_cnt]   = size;
            blk_cnt++;
            free_units -= size;
            res = at;
          end
        end
      end
      ffa_pkg::REQ_FREE: begin
        idx = lookup(off);
        if (idx >= 0) drop_block(idx);
        else st = ffa_pkg::ST_UNKNOWN;
      end
      ffa_pkg::REQ_RESIZE: begin
        idx = lookup(off);
        if (idx < 0) begin
          st = ffa_pkg::ST_UNKNOWN;
        end else if (size == 0) begin
          drop_block(idx);
        end else if (size == blk_len[idx]) begin
          res = blk_start[idx];
        end else if (size < blk_len[idx]) begin
          paint(blk_start[idx] + size, blk_len[idx] - size, 1'b0);
          free_units  += blk_len[idx] - size;
          blk_len[idx] = size;
          res = blk_start[idx];
        end else begin
          grow = size - blk_len[idx];
          at   = (grow > free_units) ? -1 : first_fit(size);
          if (at < 0) begin
            st = ffa_pkg::ST_NOSPACE;
          end else begin
            paint(blk_start[idx], blk_len[idx], 1'b0);
            paint(at, size, 1'b1);
            blk_start[idx] = at;
            blk_len[idx]   = size;
            free_units    -= grow;
            res = at;
          end
        end
      end
      default: st = ffa_pkg::ST_UNKNOWN;
    endcase
    if (st != ffa_pkg::ST_OK) res = 0;
    exp_status.push_back(st);
    exp_offset.push_back(res[9:0]);
  endfunction

  // Compare one result word with the oldest prediction.
  function void check_result(logic [1:0] st, logic [9:0] off);
    ffa_pkg::status_e es;
    logic [9:0]       eo;
    if (exp_status.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word: status %0d offset %0d", st, off);
      return;
    end
    es = exp_status.pop_front();
    eo = exp_offset.pop_front();
    if (st !== es || off !== eo) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                 es, st, eo, off);
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module first_fit_unit_allocator_top_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Worst case per request grows with the pool size; keep plenty of margin.
  localparam int CYCLE_LIMIT = 10000000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [ffa_pkg::PADDR_W-1:0] paddr;
  logic [ffa_pkg::PDATA_W-1:0] pwdata;
  logic [ffa_pkg::PDATA_W-1:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [ffa_pkg::REQ_TYPE_W-1:0] req_type_i;
  logic [ffa_pkg::OFFSET_W-1:0]   block_offset_i;
  logic [ffa_pkg::SIZE_W-1:0]     req_size_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [ffa_pkg::STATUS_W-1:0]   status_o;
  logic [ffa_pkg::OFFSET_W-1:0]   result_offset_o;

  alloc_scoreboard sb;
  int unsigned     cycles;
  bit              no_idle;   // burst mode: both sides stop idling
  int unsigned     max_size;  // typical request size for the current phase

  first_fit_unit_allocator_top dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .req_type_i, .block_offset_i, .req_size_i,
    .out_valid_o, .out_ready_i, .status_o, .result_offset_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** first_fit_unit_allocator_top: FAILED **");
      $finish;
    end
  end

  // Result side: draw a stall per word, then hold ready until a word arrives.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(status_o, result_offset_o);
    end
  end

  // Send one request word: idle a random gap, then hold valid until accepted.
  // Valid stays high across back-to-back words so it never toggles within a step.
  task automatic send_req(logic [1:0] kind, int unsigned off, int unsigned size);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_type_i     <= kind;
    block_offset_i <= off[9:0];
    req_size_i     <= size[10:0];
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(kind, off, size);
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // APB write of pool_units: setup cycle, then access cycle until pready.
  task automatic write_pool(int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ffa_pkg::REG_POOL_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_pool(v);
  endtask

  function automatic int unsigned live_or_random();
    if (sb.blk_cnt > 0 && $urandom_range(0, 99) < 85)
      return sb.blk_start[$urandom_range(0, sb.blk_cnt - 1)];
    return $urandom_range(0, 1023);
  endfunction

  // One random request: mostly well-formed against live blocks, some noise.
  task automatic random_req();
    int unsigned r, off, size, len;
    int          idx;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_req(REQ_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1024));
    end else if (r < 48) begin
      r = $urandom_range(0, 99);
      if (r < 3)      size = 0;
      else if (r < 8) size = $urandom_range(0, 1024);
      else            size = $urandom_range(1, max_size);
      send_req(ffa_pkg::REQ_ALLOC, $urandom_range(0, 1023), size);
    end else if (r < 72) begin
      send_req(ffa_pkg::REQ_FREE, live_or_random(), $urandom_range(0, 1024));
    end else begin
      off = live_or_random();
      idx = sb.lookup(off);
      len = (idx >= 0) ? sb.blk_len[idx] : 1;
      r = $urandom_range(0, 99);
      if (r < 8)       size = 0;
      else if (r < 23) size = len;
      else if (r < 48) size = $urandom_range(1, len);
      else if (r < 90) size = len + $urandom_range(1, max_size);
      else             size = $urandom_range(0, 1024);
      if (size > 1024) size = 1024;
      send_req(ffa_pkg::REQ_RESIZE, off, size);
    end
  endtask

  task automatic random_phase(int unsigned pool, int unsigned sz, int unsigned n);
    write_pool(pool);
    max_size = sz;
    for (int unsigned i = 0; i < n; i++) begin
      // Toggle bursts now and then so some stretches run with no idling.
      if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
      random_req();
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    sb             = new();
    cycles         = 0;
    no_idle        = 1'b0;
    max_size       = 4;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    req_type_i     = ffa_pkg::REQ_ALLOC;
    block_offset_i = '0;
    req_size_i     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset pool of 1024 units.
    send_req(ffa_pkg::REQ_ALLOC, 0, 0);          // zero length
    send_req(ffa_pkg::REQ_ALLOC, 0, 1024);       // whole pool
    send_req(ffa_pkg::REQ_ALLOC, 0, 1);          // more than free
    send_req(ffa_pkg::REQ_RESIZE, 0, 1024);      // same size
    send_req(ffa_pkg::REQ_RESIZE, 0, 1000);      // shrink in place
    send_req(ffa_pkg::REQ_ALLOC, 1023, 24);      // fills the tail
    send_req(ffa_pkg::REQ_RESIZE, 0, 1001);      // grow without room
    send_req(ffa_pkg::REQ_FREE, 1023, 0);        // unknown block
    send_req(ffa_pkg::REQ_RESIZE, 1000, 0);      // resize to zero acts as free
    send_req(REQ_UNUSED, 1023, 2047 & 1024);
    send_req(ffa_pkg::REQ_RESIZE, 0, 10);
    send_req(ffa_pkg::REQ_ALLOC, 0, 5);
    send_req(ffa_pkg::REQ_RESIZE, 0, 20);        // grow relocates past the new block
    send_req(ffa_pkg::REQ_FREE, 10, 0);
    send_req(ffa_pkg::REQ_FREE, 15, 0);
    drain();

    // Directed: pool value of 0 acts as one unit.
    write_pool(0);
    send_req(ffa_pkg::REQ_ALLOC, 0, 2);
    send_req(ffa_pkg::REQ_ALLOC, 0, 1);
    send_req(ffa_pkg::REQ_ALLOC, 0, 1);
    send_req(ffa_pkg::REQ_FREE, 1, 0);           // beyond the pool
    send_req(ffa_pkg::REQ_FREE, 0, 0);
    drain();

    // Directed: value above the pool depth acts as the full depth.
    write_pool(2047);
    send_req(ffa_pkg::REQ_ALLOC, 0, 1024);
    send_req(ffa_pkg::REQ_FREE, 0, 0);
    drain();

    // Random phases, small pools mostly so the table fills often.
    random_phase(100, 3, 180);
    random_phase(33, 6, 140);
    random_phase(1, 1, 30);
    random_phase(1024, 200, 40);
    random_phase(300, 12, 150);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** first_fit_unit_allocator_top: PASSED **");
    end else begin
      $display("** first_fit_unit_allocator_top: FAILED **");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_dp.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/first_fit_unit_allocator_top.sv
hw/rtl/ffa_checker.sv
tb/sv/first_fit_unit_allocator_top_tb.sv
